/* rtl/tche_pkg.sv */
// ----------------------------------------------------------------------------
// Touch calibration package
// Field widths, register indexes and event codes shared by the touch
// calibration block and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tche_pkg;

   localparam int COEF_W     = 32;
   localparam int NUM_REGS   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int RAW_W      = 12;
   localparam int BTN_W      = 3;
   localparam int SCREEN_W   = 30;
   localparam int KIND_W     = 2;
   localparam int SLOP_QPIX  = 3;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_X_LO   = 0;
   localparam int REQ_Y_LO   = REQ_X_LO + RAW_W;
   localparam int REQ_BTN_LO = REQ_Y_LO + RAW_W;

   localparam int RSP_DATA_W = 64;
   localparam int RSP_X_LO   = 0;
   localparam int RSP_Y_LO   = RSP_X_LO + SCREEN_W;
   localparam int RSP_BTN_LO = RSP_Y_LO + SCREEN_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BTN_LO - BTN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_XX  = 3'd0,
      REG_COEF_XY  = 3'd1,
      REG_OFFSET_X = 3'd2,
      REG_COEF_YX  = 3'd3,
      REG_COEF_YY  = 3'd4,
      REG_OFFSET_Y = 3'd5,
      REG_DIVISOR  = 3'd6
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      EV_DOWN = 2'd0,
      EV_UP   = 2'd1,
      EV_MOVE = 2'd2
   } event_kind_type;

endpackage

`default_nettype wire

/* rtl/touch_calibrate_hysteresis_events.sv */
// ----------------------------------------------------------------------------
// Touch calibration with hysteresis and pen events
// Maps raw touch samples to screen pixels with an affine transform, applies
// a hysteresis of three quarter pixels per axis and reports pen down, pen up and move.
// ----------------------------------------------------------------------------
// The block takes one sample at a time and is ready for the next one only
// after it has gone back to idle. For each axis a single multiplier forms
// the two products and the offset in turn, and a shared divider then
// produces one quotient bit per cycle while it is busy. The move result of
// a sample may still wait at the output while the next sample is taken.
`default_nettype none

module touch_calibrate_hysteresis_events
   import tche_pkg::*;
#(
   parameter int RAW_BITS = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // raw_x [11:0], raw_y [23:12], buttons [26:24], zero fill above.
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // screen_x [29:0], screen_y [59:30], button_bits [62:60], zero fill above.
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   // event_kind [1:0].
   output logic [KIND_W-1:0]            rsp_tuser,
   output logic                         rsp_tlast,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [COEF_W-1:0]       csr_wdata
);

   localparam int PROD_W = COEF_W + RAW_BITS + 1;
   localparam int NUM_W  = COEF_W + RAW_BITS + 2;
   localparam logic signed [COEF_W:0] SLOP_POS = (COEF_W+1)'(SLOP_QPIX);
   localparam logic signed [COEF_W:0] SLOP_NEG = -SLOP_POS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MUL   = 7'b0000010,
      S_START = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_FIX   = 7'b0010000,
      S_EDGE  = 7'b0100000,
      S_MOVE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [COEF_W-1:0] regs_ff [NUM_REGS];

   logic [RAW_BITS-1:0]     x_ff, x_in;
   logic [RAW_BITS-1:0]     y_ff, y_in;
   logic [BTN_W-1:0]        btn_ff, btn_in;
   logic                    axis_ff, axis_in;
   logic [1:0]              mul_step_ff, mul_step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [NUM_W-1:0]  acc_ff, acc_in;
   logic [COEF_W-1:0]       held_x_ff, held_x_in;
   logic [COEF_W-1:0]       held_y_ff, held_y_in;
   logic                    pen_ff, pen_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   event_kind_type          kind_ff, kind_in;
   logic [BTN_W-1:0]        rsp_btn_ff, rsp_btn_in;
   logic                    last_ff, last_in;
   logic [SCREEN_W-1:0]     sx_ff, sx_in;
   logic [SCREEN_W-1:0]     sy_ff, sy_in;

   logic [CSR_IDX_W-1:0]    mul_idx;
   logic signed [COEF_W-1:0] mul_a;
   logic signed [RAW_BITS:0] mul_b;
   logic                    div_start;
   logic                    div_done;
   logic [COEF_W-1:0]       div_quot;
   logic [COEF_W-1:0]       held_sel;
   logic signed [COEF_W:0]  move_gap;
   logic                    big_move;
   logic [COEF_W-1:0]       held_new;
   logic                    out_free;
   logic                    edge_down;
   logic                    edge_up;

   tche_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (acc_ff),
      .denom    (regs_ff[REG_DIVISOR]),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      mul_idx = axis_ff ? CSR_IDX_W'(mul_step_ff) + CSR_IDX_W'(REG_COEF_YX)
                        : CSR_IDX_W'(mul_step_ff);
      mul_a   = regs_ff[mul_idx];
      case (mul_step_ff)
         2'd0:    mul_b = $signed({1'b0, x_ff});
         2'd1:    mul_b = $signed({1'b0, y_ff});
         default: mul_b = $signed({{RAW_BITS{1'b0}}, 1'b1});
      endcase

      held_sel = axis_ff ? held_y_ff : held_x_ff;
      move_gap = $signed({div_quot[COEF_W-1], div_quot})
               - $signed({held_sel[COEF_W-1], held_sel});
      big_move = (move_gap >= SLOP_POS) || (move_gap <= SLOP_NEG);
      held_new = big_move ? {div_quot[COEF_W-1:2], 2'b00} : held_sel;

      out_free  = !rsp_valid_ff || rsp_tready;
      edge_down = (btn_ff != '0) && !pen_ff;
      edge_up   = (btn_ff == '0) && pen_ff;
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      btn_in       = btn_ff;
      axis_in      = axis_ff;
      mul_step_in  = mul_step_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      pen_in       = pen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      kind_in      = kind_ff;
      rsp_btn_in   = rsp_btn_ff;
      last_in      = last_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in        = RAW_BITS'(req_tdata[REQ_X_LO +: RAW_W]);
               y_in        = RAW_BITS'(req_tdata[REQ_Y_LO +: RAW_W]);
               btn_in      = req_tdata[REQ_BTN_LO +: BTN_W];
               axis_in     = 1'b0;
               mul_step_in = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            prod_in     = mul_a * mul_b;
            acc_in      = (mul_step_ff == 2'd0) ? '0 : acc_ff + NUM_W'(prod_ff);
            mul_step_in = mul_step_ff + 2'd1;
            if (mul_step_ff == 2'd3) begin
               state_in = S_START;
            end
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (!axis_ff) begin
               held_x_in   = held_new;
               axis_in     = 1'b1;
               mul_step_in = '0;
               state_in    = S_MUL;
            end else begin
               held_y_in = held_new;
               state_in  = S_EDGE;
            end
         end
         S_EDGE: begin
            if (edge_down || edge_up) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = edge_down ? EV_DOWN : EV_UP;
                  rsp_btn_in   = btn_ff;
                  last_in      = 1'b0;
                  sx_in        = held_x_ff[COEF_W-1:2];
                  sy_in        = held_y_ff[COEF_W-1:2];
                  pen_in       = edge_down;
                  state_in     = S_MOVE;
               end
            end else begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = EV_MOVE;
               rsp_btn_in   = btn_ff;
               last_in      = 1'b1;
               sx_in        = held_x_ff[COEF_W-1:2];
               sy_in        = held_y_ff[COEF_W-1:2];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= S_IDLE;
         held_x_ff               <= '0;
         held_y_ff               <= '0;
         pen_ff                  <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         regs_ff[REG_COEF_XX]    <= COEF_W'(1);
         regs_ff[REG_COEF_XY]    <= '0;
         regs_ff[REG_OFFSET_X]   <= '0;
         regs_ff[REG_COEF_YX]    <= '0;
         regs_ff[REG_COEF_YY]    <= COEF_W'(1);
         regs_ff[REG_OFFSET_Y]   <= '0;
         regs_ff[REG_DIVISOR]    <= COEF_W'(1);
      end else begin
         state_ff     <= state_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index <= CSR_IDX_W'(REG_DIVISOR))) begin
            regs_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      btn_ff      <= btn_in;
      axis_ff     <= axis_in;
      mul_step_ff <= mul_step_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      kind_ff     <= kind_in;
      rsp_btn_ff  <= rsp_btn_in;
      last_ff     <= last_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_btn_ff, sy_ff, sx_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a sample is still being processed");

   a_last_is_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_ff == (kind_ff == EV_MOVE)))
      else $error("last flag does not match the move event");

   a_pen_edge_event: assert property (@(posedge clock) disable iff (reset)
      (pen_ff != $past(pen_ff)) |-> (rsp_valid_ff && !last_ff))
      else $error("pen state changed without a pen event");

endmodule

`default_nettype wire

/* rtl/tche_div.sv */
// ----------------------------------------------------------------------------
// Touch calibration divider
// Signed restoring divider, one quotient bit per cycle. The quotient
// truncates toward zero, wraps to 32 bits and is zero for a zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tche_div
   import tche_pkg::*;
#(
   parameter int NUM_W = 46
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NUM_W-1:0]  numer,
   input  wire logic signed [COEF_W-1:0] denom,
   output logic                          done,
   output logic [COEF_W-1:0]             quotient
);

   localparam int MAG_W = NUM_W - 1;
   localparam int CNT_W = $clog2(MAG_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0] q_ff, q_in;
   logic [COEF_W-1:0] r_ff, r_in;
   logic [COEF_W-1:0] d_ff, d_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;

   logic [NUM_W-1:0]  numer_abs;
   logic [COEF_W-1:0] denom_abs;
   logic [COEF_W:0]   r_shift;
   logic [COEF_W+1:0] diff;

   always_comb begin
      numer_abs = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
      denom_abs = denom[COEF_W-1] ? COEF_W'(-denom) : COEF_W'(denom);
      r_shift   = {r_ff, q_ff[MAG_W-1]};
      diff      = {1'b0, r_shift} - {2'b00, d_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MAG_W - 1);
         q_in    = numer_abs[MAG_W-1:0];
         r_in    = '0;
         d_in    = denom_abs;
         neg_in  = numer[NUM_W-1] ^ denom[COEF_W-1];
         zero_in = (denom == '0);
      end else if (busy_ff) begin
         if (!diff[COEF_W+1]) begin
            r_in = diff[COEF_W-1:0];
            q_in = {q_ff[MAG_W-2:0], 1'b1};
         end else begin
            r_in = r_shift[COEF_W-1:0];
            q_in = {q_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (neg_ff) begin
         quotient = COEF_W'(-q_ff[COEF_W-1:0]);
      end else begin
         quotient = q_ff[COEF_W-1:0];
      end
   end

   assign done = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("divider done while still busy");

endmodule

`default_nettype wire
